[rtl/rri_pkg.sv]
package rri_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int COORD_BITS  = 21;
    localparam int MIN_T       = 1;
    localparam int OFFSET_DIST = 4;

    localparam int VEC_W   = 63;
    localparam int LEN_W   = 20;
    localparam int COLOR_W = 24;
    localparam int DIST_W  = 32;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 63;

    // Numerator magnitude width (|numer|, before << FRAC_BITS) and divisor width
    localparam int NUM_W = 45;
    localparam int DEN_W = 44;
    localparam int DIVIDEND_W = NUM_W + FRAC_BITS;
    // Quotient must hold values up to 2^33 to detect saturation
    localparam int Q_W = 33;

    typedef enum logic [IDX_W-1:0] {
        REG_CORNER   = 3'd0,
        REG_NORMAL   = 3'd1,
        REG_EDGE_U   = 3'd2,
        REG_EDGE_V   = 3'd3,
        REG_U_LENGTH = 3'd4,
        REG_V_LENGTH = 3'd5,
        REG_COLOR    = 3'd6,
        REG_EMITTER  = 3'd7
    } cfg_idx_t;

endpackage

[rtl/rri_divider.sv]
// Pipelined restoring divider: one quotient bit per stage.
module rri_divider #(
    parameter int N_W = rri_pkg::DIVIDEND_W,
    parameter int D_W = rri_pkg::DEN_W,
    parameter int Q_W = rri_pkg::Q_W,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W:0]     quotient,
    output logic [TAG_W-1:0] out_tag
);
    import rri_pkg::*;

    // Quotient bits above Q_W are collapsed to an overflow flag up front.
    logic [N_W-1:0]   num_reg   [Q_W+1];
    logic [D_W-1:0]   den_reg   [Q_W+1];
    logic [D_W:0]     rem_reg   [Q_W+1];
    logic [Q_W-1:0]   q_reg     [Q_W+1];
    logic             ovf_reg   [Q_W+1];
    logic [TAG_W-1:0] tag_reg   [Q_W+1];
    logic             vld_reg   [Q_W+1];

    logic ovf_next;
    logic [N_W+D_W:0] hi_part;

    // Overflow when dividend >= divisor << Q_W
    always_comb begin
        hi_part  = {{(D_W+1){1'b0}}, dividend};
        ovf_next = (hi_part >= ({{(N_W+1){1'b0}}, divisor} << Q_W));
    end

    // Load stage
    // The leading dividend bits above Q_W enter the remainder first:
    // without overflow, dividend >> Q_W is already below the divisor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            num_reg[0] <= dividend;
            den_reg[0] <= divisor;
            rem_reg[0] <= ovf_next ? '0 : (D_W+1)'(dividend >> Q_W);
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= in_tag;
        end
    end

    // Bit stages, high quotient bit first
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int BIT = Q_W - 1 - s;
        logic [N_W+D_W:0] rem_ext;
        logic [D_W:0]     trial;
        logic             take;
        logic [D_W:0]     rem_next;
        always_comb begin
            // remainder before this bit: dividend >> BIT minus subtracted part
            rem_ext = {{(D_W+1){1'b0}}, num_reg[s]} >> BIT;
            trial   = {rem_reg[s][D_W-1:0], 1'b0} | {{D_W{1'b0}}, rem_ext[0]};
            take    = (trial >= {1'b0, den_reg[s]});
            rem_next = take ? (trial - {1'b0, den_reg[s]}) : trial;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
            if (en) begin
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                rem_reg[s+1] <= rem_next;
                q_reg[s+1]   <= q_reg[s] | ({{(Q_W-1){1'b0}}, take} << BIT);
                ovf_reg[s+1] <= ovf_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quotient  = {ovf_reg[Q_W], q_reg[Q_W]};
    assign out_tag   = tag_reg[Q_W];

endmodule

[rtl/ray_rectangle_intersection.sv]
// Pipeline: 40 register stages (two product/sum stages, 34 divider stages
// and four stages after the divider).
// Throughput: one ray per cycle; all stages advance together whenever the
// output register is empty or being taken.
// Reset: synchronous active-low aresetn clears all valid bits and all
// configuration registers to zero.
module ray_rectangle_intersection #(
    parameter int MIN_T       = rri_pkg::MIN_T,
    parameter int OFFSET_DIST = rri_pkg::OFFSET_DIST
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rri_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rri_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [20:0]         s_ray_origin_x,
    input  logic signed [20:0]         s_ray_origin_y,
    input  logic signed [20:0]         s_ray_origin_z,
    input  logic signed [20:0]         s_ray_dir_x,
    input  logic signed [20:0]         s_ray_dir_y,
    input  logic signed [20:0]         s_ray_dir_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [31:0]                m_hit_distance,
    output logic signed [20:0]         m_point_x,
    output logic signed [20:0]         m_point_y,
    output logic signed [20:0]         m_point_z,
    output logic signed [20:0]         m_facing_normal_x,
    output logic signed [20:0]         m_facing_normal_y,
    output logic signed [20:0]         m_facing_normal_z,
    output logic [19:0]                m_u_coord,
    output logic [19:0]                m_v_coord,
    output logic [23:0]                m_color_out,
    output logic                       m_emitter_hit
);
    import rri_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int PW = 2 * CW + 1;   // product of two coords, plus sign room
    localparam int SW = PW + 2;       // sum of three products
    localparam int TAG_W = 3 * CW + 3 * CW + 1 + 1;
    localparam int PT = DIST_W + CW + 1; // t*D product
    localparam int PPW = PT - FRAC_BITS + 2; // hit point width
    localparam int UW = PPW + CW + 3;      // (P-C).U sum width

    // ---------------- configuration registers ----------------
    logic [VEC_W-1:0]   corner_reg, normal_reg, eu_reg, ev_reg;
    logic [LEN_W-1:0]   ulen_reg, vlen_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               emit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= '0; normal_reg <= '0; eu_reg <= '0; ev_reg <= '0;
            ulen_reg   <= '0; vlen_reg   <= '0; color_reg <= '0; emit_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CORNER:   corner_reg <= cfg_data[VEC_W-1:0];
                REG_NORMAL:   normal_reg <= cfg_data[VEC_W-1:0];
                REG_EDGE_U:   eu_reg     <= cfg_data[VEC_W-1:0];
                REG_EDGE_V:   ev_reg     <= cfg_data[VEC_W-1:0];
                REG_U_LENGTH: ulen_reg   <= cfg_data[LEN_W-1:0];
                REG_V_LENGTH: vlen_reg   <= cfg_data[LEN_W-1:0];
                REG_COLOR:    color_reg  <= cfg_data[COLOR_W-1:0];
                REG_EMITTER:  emit_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] c [3], n [3], uu [3], vv [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c[k]  = corner_reg[k*21 +: CW];
            n[k]  = normal_reg[k*21 +: CW];
            uu[k] = eu_reg[k*21 +: CW];
            vv[k] = ev_reg[k*21 +: CW];
        end
    end

    // Global advance: the pipeline moves when the output slot frees.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: products ----------------
    logic                 v1_reg;
    logic signed [CW-1:0] e1_reg [3], d1_reg [3];
    logic signed [PW-1:0] pn1_reg [3], pd1_reg [3];
    logic signed [CW-1:0] e_in [3], d_in [3];
    assign e_in[0] = s_ray_origin_x[CW-1:0];
    assign e_in[1] = s_ray_origin_y[CW-1:0];
    assign e_in[2] = s_ray_origin_z[CW-1:0];
    assign d_in[0] = s_ray_dir_x[CW-1:0];
    assign d_in[1] = s_ray_dir_y[CW-1:0];
    assign d_in[2] = s_ray_dir_z[CW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_valid;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                e1_reg[k]  <= e_in[k];
                d1_reg[k]  <= d_in[k];
                pn1_reg[k] <= PW'((CW+1)'(c[k]) - (CW+1)'(e_in[k])) * PW'(n[k]);
                pd1_reg[k] <= PW'(d_in[k]) * PW'(n[k]);
            end
        end
    end

    // ---------------- stage 2: sums, magnitudes ----------------
    logic                 v2_reg, neg2_reg, dneg2_reg, dz2_reg;
    logic signed [CW-1:0] e2_reg [3], d2_reg [3];
    logic [NUM_W-1:0]     an2_reg;
    logic [DEN_W-1:0]     ad2_reg;
    logic signed [SW-1:0] numer, denom;
    always_comb begin
        numer = SW'(pn1_reg[0]) + SW'(pn1_reg[1]) + SW'(pn1_reg[2]);
        denom = SW'(pd1_reg[0]) + SW'(pd1_reg[1]) + SW'(pd1_reg[2]);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
        if (en) begin
            e2_reg    <= e1_reg;
            d2_reg    <= d1_reg;
            neg2_reg  <= numer[SW-1] != denom[SW-1];
            dneg2_reg <= denom[SW-1];
            dz2_reg   <= denom == '0;
            an2_reg   <= NUM_W'(numer[SW-1] ? -numer : numer);
            ad2_reg   <= DEN_W'(denom[SW-1] ? -denom : denom);
        end
    end

    // ---------------- divider ----------------
    logic [TAG_W-1:0] tag_in, tag_out;
    logic             dv_valid;
    logic [Q_W:0]     quo;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
    assign dividend = {an2_reg, {FRAC_BITS{1'b0}}};
    assign divisor  = dz2_reg ? DEN_W'(1) : ad2_reg;
    assign tag_in   = {e2_reg[0], e2_reg[1], e2_reg[2],
                       d2_reg[0], d2_reg[1], d2_reg[2], dneg2_reg, dz2_reg};

    rri_divider #(.N_W(DIVIDEND_W), .D_W(DEN_W), .Q_W(Q_W), .TAG_W(TAG_W)) u_div (
        .aclk, .aresetn, .en,
        .in_valid (v2_reg),
        .dividend,
        .divisor,
        .in_tag   (tag_in),
        .out_valid(dv_valid),
        .quotient (quo),
        .out_tag  (tag_out)
    );

    // neg flag rides a separate shift line alongside the divider
    logic negd_reg [Q_W+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            negd_reg[0] <= neg2_reg;
            for (int s = 1; s <= Q_W; s++) negd_reg[s] <= negd_reg[s-1];
        end
    end

    // ---------------- stage 3: t qualify, t*D ----------------
    logic                 v3_reg, miss3_reg, dneg3_reg;
    logic [DIST_W-1:0]    t3_reg;
    logic signed [CW-1:0] e3_reg [3], d3_reg [3];
    logic signed [PT-1:0] td3_reg [3];
    logic signed [CW-1:0] e_o [3], d_o [3];
    logic [DIST_W-1:0]    t_sat;
    logic                 miss_t;
    always_comb begin
        {e_o[0], e_o[1], e_o[2], d_o[0], d_o[1], d_o[2]} = tag_out[TAG_W-1:2];
        t_sat  = (quo[Q_W:DIST_W] != '0) ? '1 : quo[DIST_W-1:0];
        miss_t = tag_out[0] || (negd_reg[Q_W] && quo != '0) ||
                 ((Q_W+1)'(quo) < (Q_W+1)'(MIN_T));
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= dv_valid;
        if (en) begin
            t3_reg    <= t_sat;
            miss3_reg <= miss_t;
            dneg3_reg <= tag_out[1];
            e3_reg    <= e_o;
            d3_reg    <= d_o;
            for (int k = 0; k < 3; k++)
                td3_reg[k] <= $signed({1'b0, t_sat}) * PT'(d_o[k]);
        end
    end

    // ---------------- stage 4: hit point, P-C ----------------
    logic                  v4_reg, miss4_reg, dneg4_reg;
    logic [DIST_W-1:0]     t4_reg;
    logic signed [PPW-1:0] p4_reg [3], pc4_reg [3];
    logic signed [PPW-1:0] p_n [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            p_n[k] = PPW'(e3_reg[k]) + PPW'(td3_reg[k] >>> FRAC_BITS);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
        if (en) begin
            miss4_reg <= miss3_reg;
            dneg4_reg <= dneg3_reg;
            t4_reg    <= t3_reg;
            for (int k = 0; k < 3; k++) begin
                p4_reg[k]  <= p_n[k];
                pc4_reg[k] <= p_n[k] - PPW'(c[k]);
            end
        end
    end

    // ---------------- stage 5: projection products, offset point ----------------
    logic                 v5_reg, miss5_reg;
    logic [DIST_W-1:0]    t5_reg;
    logic signed [UW-1:0] pu5_reg [3], pv5_reg [3];
    logic signed [CW-1:0] nf5_reg [3], q5_reg [3];
    logic signed [CW-1:0] nf [3];
    logic signed [PPW+1:0] qsum [3];
    logic signed [CW+9:0]  noff [3];
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nf[k]   = dneg4_reg ? n[k] : ((n[k] == CMIN) ? CMAX : -n[k]);
            noff[k] = (CW+10)'(nf[k]) * (CW+10)'(OFFSET_DIST);
            qsum[k] = (PPW+2)'(p4_reg[k]) + (PPW+2)'(noff[k] >>> FRAC_BITS);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
        if (en) begin
            miss5_reg <= miss4_reg;
            t5_reg    <= t4_reg;
            for (int k = 0; k < 3; k++) begin
                pu5_reg[k] <= UW'(pc4_reg[k]) * UW'(uu[k]);
                pv5_reg[k] <= UW'(pc4_reg[k]) * UW'(vv[k]);
                nf5_reg[k] <= nf[k];
                q5_reg[k]  <= (qsum[k] > (PPW+2)'(CMAX)) ? CMAX :
                              (qsum[k] < (PPW+2)'(CMIN)) ? CMIN : CW'(qsum[k]);
            end
        end
    end

    // ---------------- stage 6: bounds, output register ----------------
    logic signed [UW+1:0] du, dv, x, y;
    logic                 hit_n;
    always_comb begin
        du = (UW+2)'(pu5_reg[0]) + (UW+2)'(pu5_reg[1]) + (UW+2)'(pu5_reg[2]);
        dv = (UW+2)'(pv5_reg[0]) + (UW+2)'(pv5_reg[1]) + (UW+2)'(pv5_reg[2]);
        x  = du >>> FRAC_BITS;
        y  = dv >>> FRAC_BITS;
        hit_n = !miss5_reg && !x[UW+1] && !y[UW+1] &&
                x <= (UW+2)'(ulen_reg) && y <= (UW+2)'(vlen_reg);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (en)  m_valid <= v5_reg;
        if (en) begin
            m_hit             <= hit_n;
            m_hit_distance    <= hit_n ? t5_reg : '0;
            m_point_x         <= hit_n ? 21'(q5_reg[0]) : '0;
            m_point_y         <= hit_n ? 21'(q5_reg[1]) : '0;
            m_point_z         <= hit_n ? 21'(q5_reg[2]) : '0;
            m_facing_normal_x <= hit_n ? 21'(nf5_reg[0]) : '0;
            m_facing_normal_y <= hit_n ? 21'(nf5_reg[1]) : '0;
            m_facing_normal_z <= hit_n ? 21'(nf5_reg[2]) : '0;
            m_u_coord         <= hit_n ? x[19:0] : '0;
            m_v_coord         <= hit_n ? y[19:0] : '0;
            m_color_out       <= hit_n ? color_reg : '0;
            m_emitter_hit     <= hit_n ? emit_reg : 1'b0;
        end
    end

endmodule

[rtl/rri_checker.sv]
module rri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [31:0] m_hit_distance,
    input logic [23:0] m_color_out
);
    // A held result stays valid and keeps its hit distance.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_distance))
        else $error("result dropped or changed while stalled");

    // Input side stalls exactly when a result is stuck.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output slot");

    // A miss carries zero hit distance and zero color.
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_distance == 32'd0 && m_color_out == 24'd0)
        else $error("miss with nonzero payload");

    // No result out of reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind ray_rectangle_intersection rri_checker u_rri_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready,
    .m_hit, .m_hit_distance, .m_color_out
);
